FILE: hw/rtl/saq_pkg.sv
// Types, codes and constants shared by the sorted alarm queue modules.
package saq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned MAX_RESULTS  = 16;
  localparam int unsigned CNT_W        = $clog2(MAX_RESULTS);

  // request modes
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_POLL   = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  // result status codes
  localparam logic [2:0] STS_FIRED      = 3'd0;
  localparam logic [2:0] STS_SET_OK     = 3'd1;
  localparam logic [2:0] STS_FULL       = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND  = 3'd3;
  localparam logic [2:0] STS_CANCEL_OK  = 3'd4;
  localparam logic [2:0] STS_NONE_DUE   = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  alarm_id;
    logic [63:0] deadline_us;
    logic [63:0] now_us;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  alarm_id_res;
    logic [63:0] deadline_us_res;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [63:0] deadline;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE
  } cell_cmd_e;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_e   cmd;
    logic [7:0]  id;
    logic [63:0] key;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_CAN_MATCH,
    S_CAN_APPLY,
    S_POLL
  } state_e;

endpackage

FILE: hw/rtl/sorted_alarm_queue_top.sv
// Top level of the sorted alarm queue: request control and the cell chain.
//
//   channel   ports                     handshake
//   request   req_i (req_t)             start_i high and busy_o low at the edge
//   result    res_o (res_t)             res_strobe_o high for one cycle
//
// Steps: set captures the request, then does one parallel compare/shift step
// in all cells; cancel captures, scans for a match, then does the remove step;
// poll captures, then emits the head cell and shifts the chain left once per
// cycle for each fired entry, or gives a single result when nothing is due.
// Each result is registered and appears in the cycle after its step; a request
// with mode three produces nothing and busy_o never rises.
// Reset clears all valid bits, the state machine and the result strobe.
// The receiver cannot stall; results are never held back.
module sorted_alarm_queue_top
  import saq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_strobe_o,
  output res_t res_o
);

  state_e state_q, state_d;
  req_t   req_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CAPACITY-1:0] match_q, match_d;
  logic                res_strobe_q, res_strobe_d;
  res_t                res_q, res_d;

  cell_ctrl_t          ctrl;
  logic [CAPACITY-1:0] shift_mask;
  logic [CAPACITY-1:0] lowest;
  logic [CAPACITY-1:0] le_w, match_w, valid_w;
  entry_t              entry_w [CAPACITY];

  logic accept;
  logic last_fire;

  assign busy_o       = (state_q != S_IDLE);
  assign accept       = start_i && !busy_o;
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  // First matching slot; slots from there on shift left on a cancel.
  assign lowest = match_q & (~match_q + CAPACITY'(1));

  // Poll stops after this fire if the next entry is not due or the cap is hit.
  assign last_fire = !le_w[1] || (cnt_q == CNT_W'(MAX_RESULTS - 1));

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_le;

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_le = 1'b1;
    end else begin : g_mid
      assign left_e  = entry_w[i-1];
      assign left_le = le_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = entry_w[i+1];
    end

    saq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_entry_i  (left_e),
      .left_le_i     (left_le),
      .right_entry_i (right_e),
      .shift_i       (shift_mask[i]),
      .entry_o       (entry_w[i]),
      .le_o          (le_w[i]),
      .match_o       (match_w[i])
    );

    assign valid_w[i] = entry_w[i].valid;
  end

  // ---------------- control ----------------
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    match_d      = match_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    shift_mask   = '0;
    ctrl.cmd     = CMD_HOLD;
    ctrl.id      = req_q.alarm_id;
    ctrl.key     = (req_q.mode == MODE_POLL) ? req_q.now_us : req_q.deadline_us;

    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          unique case (req_i.mode)
            MODE_SET:    state_d = S_SET;
            MODE_CANCEL: state_d = S_CAN_MATCH;
            MODE_POLL:   state_d = S_POLL;
            default:     state_d = S_IDLE;
          endcase
        end
      end

      S_SET: begin
        res_strobe_d = 1'b1;
        res_d        = '{status: STS_SET_OK, alarm_id_res: req_q.alarm_id,
                         deadline_us_res: req_q.deadline_us, last: 1'b1};
        if (valid_w[CAPACITY-1]) begin
          res_d.status = STS_FULL;
        end else begin
          ctrl.cmd = CMD_INSERT;
        end
        state_d = S_IDLE;
      end

      S_CAN_MATCH: begin
        match_d = match_w;
        state_d = S_CAN_APPLY;
      end

      S_CAN_APPLY: begin
        ctrl.cmd     = CMD_REMOVE;
        shift_mask   = ~(lowest - CAPACITY'(1));
        res_strobe_d = 1'b1;
        res_d        = '{status: (|match_q) ? STS_CANCEL_OK : STS_NOT_FOUND,
                         alarm_id_res: req_q.alarm_id,
                         deadline_us_res: req_q.deadline_us, last: 1'b1};
        state_d      = S_IDLE;
      end

      S_POLL: begin
        res_strobe_d = 1'b1;
        if (le_w[0]) begin
          ctrl.cmd   = CMD_REMOVE;
          shift_mask = '1;
          res_d      = '{status: STS_FIRED, alarm_id_res: entry_w[0].id,
                         deadline_us_res: entry_w[0].deadline, last: last_fire};
          cnt_d      = cnt_q + CNT_W'(1);
          if (last_fire) begin
            state_d = S_IDLE;
          end
        end else begin
          res_d   = '{status: STS_NONE_DUE, alarm_id_res: '0,
                      deadline_us_res: '0, last: 1'b1};
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    match_q <= match_d;
    res_q   <= res_d;
  end

  // ---------------- assertions ----------------
`ifndef ASSERT_OFF
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.mode != MODE_IGNORE)) |=> busy_o)
    else $error("busy did not rise after an accepted request");

  a_packed_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_w + CAPACITY'(1)) & valid_w) == '0)
    else $error("valid entries are not packed at the head of the chain");

  a_single_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CAN_APPLY) |-> $onehot0(lowest))
    else $error("cancel selects more than one slot");

  a_nonfire_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && (res_o.status != STS_FIRED)) |-> res_o.last)
    else $error("single-result response without last");
`endif

endmodule

FILE: hw/rtl/saq_cell.sv
// One slot of the sorted alarm chain: holds an entry, compares it, shifts.
module saq_cell
  import saq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_entry_i,
  input  logic       left_le_i,
  input  entry_t     right_entry_i,
  input  logic       shift_i,
  output entry_t     entry_o,
  output logic       le_o,
  output logic       match_o
);

  logic        valid_q, valid_d;
  logic [7:0]  id_q, id_d;
  logic [63:0] dl_q, dl_d;

  assign entry_o = '{valid: valid_q, id: id_q, deadline: dl_q};
  assign le_o    = valid_q && (dl_q <= ctrl_i.key);
  assign match_o = valid_q && (dl_q == ctrl_i.key) && (id_q == ctrl_i.id);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    dl_d    = dl_q;
    unique case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (!le_o) begin
          if (left_le_i) begin
            valid_d = 1'b1;
            id_d    = ctrl_i.id;
            dl_d    = ctrl_i.key;
          end else begin
            valid_d = left_entry_i.valid;
            id_d    = left_entry_i.id;
            dl_d    = left_entry_i.deadline;
          end
        end
      end
      CMD_REMOVE: begin
        if (shift_i) begin
          valid_d = right_entry_i.valid;
          id_d    = right_entry_i.id;
          dl_d    = right_entry_i.deadline;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    dl_q <= dl_d;
  end

endmodule

FILE: test/alarm_queue_checker.sv
// Watches the request and result channels, predicts each result and compares.
module alarm_queue_checker
  import saq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        res_strobe_i,
  input  res_t        res_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam int unsigned SLOTS = CAPACITY_DEF;

  // mirror of the sorted entry store, packed in slots 0..mir_count-1
  logic [63:0] mir_deadline [SLOTS];
  logic [7:0]  mir_id       [SLOTS];
  int unsigned mir_count;

  res_t        awaited_q [$];
  int unsigned err_count;

  function automatic res_t mk_res(logic [2:0] st, logic [7:0] id, logic [63:0] dl,
                                  logic last);
    res_t r;
    r.status          = st;
    r.alarm_id_res    = id;
    r.deadline_us_res = dl;
    r.last            = last;
    return r;
  endfunction

  task automatic drop_slot(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < mir_count; i++) begin
      mir_deadline[i] = mir_deadline[i + 1];
      mir_id[i]       = mir_id[i + 1];
    end
    mir_count--;
  endtask

  task automatic predict_alarm_results(input req_t rq);
    int unsigned pos;
    int unsigned i;
    int unsigned fired;
    bit          hit;
    res_t        tail;
    case (rq.mode)
      MODE_SET: begin
        if (mir_count >= SLOTS) begin
          awaited_q.push_back(mk_res(STS_FULL, rq.alarm_id, rq.deadline_us, 1'b1));
        end else begin
          // equal deadlines go behind the ones already queued
          pos = 0;
          while (pos < mir_count && mir_deadline[pos] <= rq.deadline_us) pos++;
          for (i = mir_count; i > pos; i--) begin
            mir_deadline[i] = mir_deadline[i - 1];
            mir_id[i]       = mir_id[i - 1];
          end
          mir_deadline[pos] = rq.deadline_us;
          mir_id[pos]       = rq.alarm_id;
          mir_count++;
          awaited_q.push_back(mk_res(STS_SET_OK, rq.alarm_id, rq.deadline_us, 1'b1));
        end
      end
      MODE_CANCEL: begin
        hit = 1'b0;
        for (pos = 0; pos < mir_count && !hit; pos++) begin
          if (mir_deadline[pos] == rq.deadline_us && mir_id[pos] == rq.alarm_id) begin
            drop_slot(pos);
            hit = 1'b1;
          end
        end
        awaited_q.push_back(mk_res(hit ? STS_CANCEL_OK : STS_NOT_FOUND,
                                   rq.alarm_id, rq.deadline_us, 1'b1));
      end
      MODE_POLL: begin
        fired = 0;
        while (fired < MAX_RESULTS && mir_count > 0 && mir_deadline[0] <= rq.now_us) begin
          awaited_q.push_back(mk_res(STS_FIRED, mir_id[0], mir_deadline[0], 1'b0));
          drop_slot(0);
          fired++;
        end
        if (fired == 0) begin
          awaited_q.push_back(mk_res(STS_NONE_DUE, 8'd0, 64'd0, 1'b1));
        end else begin
          tail      = awaited_q.pop_back();
          tail.last = 1'b1;
          awaited_q.push_back(tail);
        end
      end
      default: ;  // ignored mode, nothing comes back
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      mir_count = 0;
      err_count = 0;
      awaited_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // results first: a request taken at this edge only adds behind them
      if (res_strobe_i) begin
        if (awaited_q.size() == 0) begin
          err_count++;
          $display({"%0t: unexpected result, expected none, ",
                    "got status %0d id %0d deadline %h last %0d"},
                   $time, res_i.status, res_i.alarm_id_res, res_i.deadline_us_res,
                   res_i.last);
        end else begin
          want = awaited_q.pop_front();
          if (res_i.status !== want.status || res_i.alarm_id_res !== want.alarm_id_res ||
              res_i.deadline_us_res !== want.deadline_us_res ||
              res_i.last !== want.last) begin
            err_count++;
            $display({"%0t: result mismatch, ",
                      "expected status %0d id %0d deadline %h last %0d, ",
                      "got status %0d id %0d deadline %h last %0d"},
                     $time, want.status, want.alarm_id_res, want.deadline_us_res,
                     want.last, res_i.status, res_i.alarm_id_res,
                     res_i.deadline_us_res, res_i.last);
          end
        end
      end
      if (start_i && !busy_i) predict_alarm_results(req_i);
      errors_o  <= err_count;
      pending_o <= awaited_q.size();
    end
  end

endmodule

FILE: test/tb_sorted_alarm_queue_top.sv
// Testbench top for the sorted alarm queue: stimulus, watchdog and verdict.
module tb_sorted_alarm_queue_top;
  import saq_pkg::*;

  // Worst case is a poll draining a full queue, plus gaps.
  // A few hundred items stay far below this.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_REQS = 350;
  // requests in [CALM_FROM, CALM_TO) go back to back with no gaps
  localparam int unsigned CALM_FROM   = 120;
  localparam int unsigned CALM_TO     = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  req_t        req_i;
  logic        busy_o;
  logic        res_strobe_o;
  res_t        res_o;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycles;

  // stimulus state: a running microsecond clock and recently set alarms
  logic [63:0] clock_us;
  logic [71:0] set_pool [$];

  sorted_alarm_queue_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .busy_o       (busy_o),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  alarm_queue_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .req_i        (req_i),
    .res_strobe_i (res_strobe_o),
    .res_i        (res_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result ends here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t pack_req(logic [1:0] m, logic [7:0] id, logic [63:0] dl,
                                    logic [63:0] now);
    req_t r;
    r.mode        = m;
    r.alarm_id    = id;
    r.deadline_us = dl;
    r.now_us      = now;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Hold the request up until the block takes it. busy_o is read before the
  // edge updates land, so the edge that ends the loop is the accepting one.
  // Back-to-back requests keep start_i high: it is only ever assigned once here.
  task automatic issue(input req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Sender gap; the request bus carries junk meanwhile, which must be ignored.
  task automatic idle_for(input int unsigned n);
    start_i <= 1'b0;
    req_i   <= pack_req(2'($urandom), 8'($urandom), rand64(), rand64());
    repeat (n) @(posedge clk_i);
  endtask

  // Random gap after a request, about a quarter of the time; mostly short,
  // sometimes long enough to outlast a full poll so gaps hit every phase.
  task automatic pace(input int unsigned k);
    if ((k < CALM_FROM || k >= CALM_TO) && $urandom_range(99) < 23) begin
      if ($urandom_range(9) == 0) idle_for($urandom_range(24, 5));
      else idle_for($urandom_range(3, 1));
    end
  endtask

  task automatic wait_results_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Set request near the running clock; now and then a full-range deadline
  // or an exact repeat of a queued deadline to exercise insertion order.
  task automatic random_set();
    logic [7:0]  id;
    logic [63:0] dl;
    int unsigned pick;
    id   = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) dl = rand64();
    else if (pick < 30 && set_pool.size() > 0)
      dl = set_pool[$urandom_range(set_pool.size() - 1)][63:0];
    else dl = clock_us + 64'($urandom_range(300));
    set_pool.push_back({id, dl});
    if (set_pool.size() > 32) void'(set_pool.pop_front());
    issue(pack_req(MODE_SET, id, dl, rand64()));
  endtask

  // Cancel request: mostly an alarm that was set, sometimes one with the id or
  // the deadline off by one, sometimes pure noise.
  task automatic random_cancel();
    logic [71:0] ent;
    int unsigned pick;
    pick = $urandom_range(99);
    if (set_pool.size() == 0 || pick >= 85) ent = {8'($urandom), rand64()};
    else begin
      ent = set_pool[$urandom_range(set_pool.size() - 1)];
      if (pick >= 70) ent[71:64] = ent[71:64] + 8'd1;
      else if (pick >= 60) ent[63:0] = ent[63:0] + 64'd1;
    end
    issue(pack_req(MODE_CANCEL, ent[71:64], ent[63:0], rand64()));
  endtask

  // Poll request: the clock moves forward and due entries fire; sometimes
  // the time is all ones (everything fires) or fully random.
  task automatic random_poll();
    logic [63:0] now;
    int unsigned pick;
    pick     = $urandom_range(99);
    clock_us = clock_us + 64'($urandom_range(80));
    if (pick < 8) now = '1;
    else if (pick < 15) now = rand64();
    else now = clock_us;
    issue(pack_req(MODE_POLL, 8'($urandom), rand64(), now));
  endtask

  initial begin
    int unsigned sent;
    int unsigned pick;
    rst_ni   <= 1'b0;
    start_i  <= 1'b0;
    req_i    <= '0;
    clock_us = 64'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes of id and deadline, equal deadlines in insert order,
    // cancel hit and both kinds of miss, nothing-due polls, ignored mode.
    issue(pack_req(MODE_SET, 8'd0, 64'd0, '1));
    issue(pack_req(MODE_SET, 8'd255, '1, 64'd0));
    issue(pack_req(MODE_SET, 8'd7, 64'd100, 64'd0));
    issue(pack_req(MODE_SET, 8'd8, 64'd100, 64'd0));
    issue(pack_req(MODE_SET, 8'd9, 64'd100, 64'd0));
    issue(pack_req(MODE_CANCEL, 8'd8, 64'd100, 64'd0));
    issue(pack_req(MODE_CANCEL, 8'd7, 64'd101, 64'd0));
    issue(pack_req(MODE_CANCEL, 8'd6, 64'd100, 64'd0));
    issue(pack_req(MODE_POLL, 8'd0, 64'd0, 64'd0));
    issue(pack_req(MODE_POLL, '1, '1, 64'd99));
    issue(pack_req(MODE_IGNORE, 8'd9, 64'd100, '1));
    issue(pack_req(MODE_POLL, 8'd0, 64'd0, 64'd100));
    issue(pack_req(MODE_POLL, 8'd0, 64'd0, '1 - 64'd1));
    issue(pack_req(MODE_POLL, 8'd0, 64'd0, '1));
    issue(pack_req(MODE_POLL, 8'd0, 64'd0, '1));
    issue(pack_req(MODE_CANCEL, 8'd255, '1, '1));

    // Random traffic in segments around a fresh time base.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      // let the queue drain completely once before the gap-free stretch
      if (sent == CALM_FROM) wait_results_drained();
      if (sent % 40 == 0) begin
        pick = $urandom_range(9);
        if (pick == 0) clock_us = 64'd0;
        else if (pick == 1) clock_us = 64'hFFFF_FFFF_FFFF_FE00;
        else clock_us = rand64();
      end
      if (sent % 50 == 25) begin
        // fill burst: overruns the capacity so full answers come back
        repeat (CAPACITY_DEF + 2) begin
          random_set();
          pace(sent);
          sent++;
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) random_set();
        else if (pick < 65) random_cancel();
        else if (pick < 93) random_poll();
        else issue(pack_req(MODE_IGNORE, 8'($urandom), rand64(), rand64()));
        if (pick < 93) sent++;
        pace(sent);
      end
    end

    wait_results_drained();
    // trailing cycles catch any stray result after the last expected one
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
